/* rtl/uer_pkg.sv */
package uer_pkg;

   // field widths
   localparam int TIME_W    = 32;
   localparam int CFG_W     = 16;
   localparam int RANGE_W   = 13;
   localparam int PULSE_W   = 16;
   localparam int CSR_IDX_W = 2;

   // echo timeout default, microseconds
   localparam int ECHO_TIMEOUT_US_DEF = 25000;

   // divide by 58 as multiply by reciprocal, exact for any 16 bit pulse
   localparam int RECIP_W     = 18;
   localparam int RECIP_SHIFT = 23;
   localparam logic [RECIP_W-1:0] RECIP_58 = 18'd144632;
   localparam int QUOT_W      = 11;

   localparam logic [RANGE_W-1:0] RANGE_MAX_MM = 13'd4310;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INTERVAL  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 2'd2;

   // register reset values
   localparam logic             ENABLE_RST    = 1'b1;
   localparam logic [CFG_W-1:0] INTERVAL_RST  = 16'd60;
   localparam logic [CFG_W-1:0] THRESHOLD_RST = 16'd300;

   typedef struct packed {
      logic [TIME_W-1:0] time_ms;
      logic [TIME_W-1:0] time_us;
      logic              echo_level;
   } uer_req_type;

   typedef struct packed {
      logic             enable;
      logic [CFG_W-1:0] interval_ms;
      logic [CFG_W-1:0] threshold_mm;
   } uer_cfg_type;

   typedef struct packed {
      logic               fire_trigger;
      logic               reading_done;
      logic [RANGE_W-1:0] range_mm;
      logic               range_valid;
      logic               obstacle;
      logic [TIME_W-1:0]  updated_at_ms;
   } uer_rsp_type;

endpackage

/* rtl/uer_dist.sv */
module uer_dist (
   input  logic [uer_pkg::PULSE_W-1:0] width_us,
   output logic [uer_pkg::RANGE_W-1:0] dist_mm
);
   import uer_pkg::*;

   localparam int PROD_W = PULSE_W + RECIP_W;
   localparam int MM_W   = QUOT_W + 4;

   logic [PROD_W-1:0] prod;
   logic [QUOT_W-1:0] cm;
   logic [MM_W-1:0]   mm;

   // centimetres = pulse / 58 via reciprocal
   assign prod = PROD_W'(width_us) * PROD_W'(RECIP_58);
   assign cm   = prod[RECIP_SHIFT +: QUOT_W];

   // millimetres = cm * 10 as shift and add
   assign mm = MM_W'({cm, 3'b000}) + MM_W'({cm, 1'b0});

   // saturate to the maximum range
   assign dist_mm = (mm > MM_W'(RANGE_MAX_MM)) ? RANGE_MAX_MM : mm[RANGE_W-1:0];

endmodule

/* rtl/uer_core.sv */
module uer_core #(
   parameter int ECHO_TIMEOUT_US = uer_pkg::ECHO_TIMEOUT_US_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  uer_pkg::uer_req_type req,
   input  uer_pkg::uer_cfg_type cfg,
   output uer_pkg::uer_rsp_type rsp
);
   import uer_pkg::*;

   localparam logic [1:0] PH_IDLE      = 2'd0;
   localparam logic [1:0] PH_WAIT_RISE = 2'd1;
   localparam logic [1:0] PH_ECHO_HIGH = 2'd2;

   localparam logic [TIME_W-1:0] TIMEOUT = TIME_W'(ECHO_TIMEOUT_US);

   logic [1:0]         phase_ff, phase_in;
   logic [TIME_W-1:0]  last_start_ff, last_start_in;
   logic [TIME_W-1:0]  trig_us_ff, trig_us_in;
   logic [TIME_W-1:0]  rise_us_ff, rise_us_in;
   logic [RANGE_W-1:0] range_ff, range_in;
   logic               valid_ff, valid_in;
   logic               obst_ff, obst_in;
   logic [TIME_W-1:0]  upd_ms_ff, upd_ms_in;

   logic [TIME_W-1:0]  since_trig;
   logic [TIME_W-1:0]  pulse;
   logic [TIME_W-1:0]  since_start;
   logic [RANGE_W-1:0] echo_mm;
   logic               fire;
   logic               done;
   logic               finish;
   logic               fin_valid;
   logic [RANGE_W-1:0] fin_dist;

   // timestamp differences, wrapping
   assign since_trig  = req.time_us - trig_us_ff;
   assign pulse       = req.time_us - rise_us_ff;
   assign since_start = req.time_ms - last_start_ff;

   // echo width to distance
   uer_dist u_dist (
      .width_us (pulse[PULSE_W-1:0]),
      .dist_mm  (echo_mm)
   );

   // phase sequencing
   always_comb begin
      phase_in      = phase_ff;
      trig_us_in    = trig_us_ff;
      rise_us_in    = rise_us_ff;
      fire          = 1'b0;
      finish        = 1'b0;
      fin_valid     = 1'b0;
      fin_dist      = '0;
      if (cfg.enable) begin
         case (phase_ff)
            PH_WAIT_RISE: begin
               if (since_trig > TIMEOUT) begin
                  finish = 1'b1;
               end else if (req.echo_level) begin
                  rise_us_in = req.time_us;
                  phase_in   = PH_ECHO_HIGH;
               end
            end
            PH_ECHO_HIGH: begin
               if (pulse > TIMEOUT) begin
                  finish = 1'b1;
               end else if (!req.echo_level) begin
                  finish    = 1'b1;
                  fin_valid = 1'b1;
                  fin_dist  = echo_mm;
               end
            end
            default: begin
               if (since_start >= TIME_W'(cfg.interval_ms)) begin
                  trig_us_in = req.time_us;
                  phase_in   = PH_WAIT_RISE;
                  fire       = 1'b1;
               end
            end
         endcase
         if (finish) begin
            phase_in = PH_IDLE;
         end
      end
   end

   assign done = finish;

   // held reading
   always_comb begin
      last_start_in = last_start_ff;
      range_in      = range_ff;
      valid_in      = valid_ff;
      obst_in       = obst_ff;
      upd_ms_in     = upd_ms_ff;
      if (!cfg.enable) begin
         obst_in = 1'b0;
      end else if (finish) begin
         last_start_in = req.time_ms;
         upd_ms_in     = req.time_ms;
         range_in      = fin_dist;
         valid_in      = fin_valid;
         obst_in       = fin_valid && (cfg.threshold_mm != '0) && (fin_dist != '0)
                         && (CFG_W'(fin_dist) < cfg.threshold_mm);
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         last_start_ff <= '0;
         trig_us_ff    <= '0;
         rise_us_ff    <= '0;
         range_ff      <= '0;
         valid_ff      <= 1'b0;
         obst_ff       <= 1'b0;
         upd_ms_ff     <= '0;
      end else if (step) begin
         phase_ff      <= phase_in;
         last_start_ff <= last_start_in;
         trig_us_ff    <= trig_us_in;
         rise_us_ff    <= rise_us_in;
         range_ff      <= range_in;
         valid_ff      <= valid_in;
         obst_ff       <= obst_in;
         upd_ms_ff     <= upd_ms_in;
      end
   end

   // result of this request
   assign rsp.fire_trigger  = fire;
   assign rsp.reading_done  = done;
   assign rsp.range_mm      = range_in;
   assign rsp.range_valid   = valid_in;
   assign rsp.obstacle      = obst_in;
   assign rsp.updated_at_ms = upd_ms_in;

endmodule

/* rtl/ultrasonic_echo_ranger.sv */
// Ultrasonic echo ranging sequencer.
// Each request on the req_ channel is one polling tick: millisecond and
// microsecond timestamps plus the sampled echo pin level. Every request gives
// exactly one response on the rsp_ channel: whether to fire a trigger pulse,
// whether a reading finished on this tick, and the held distance, validity,
// obstacle flag and update time.
// Registers are written through the csr_ channel (index 0 enable, 1 interval
// in ms, 2 obstacle threshold in mm); csr_ready is always high and other
// indexes are ignored. Write them only while no request is in flight.
// A request passes the input register, then the sequencer step into the output
// register. One request is taken every cycle while rsp_ready holds high; the
// sequencer state updates as a request moves to the output register.
// When the receiver stalls, the output register holds its response and the
// input register fills; req_ready then drops until rsp_ready returns.
// Reset (synchronous) empties both registers, returns the sequence to idle,
// clears the held reading and loads enable 1, interval 60 ms, threshold 300 mm.
module ultrasonic_echo_ranger #(
   parameter int ECHO_TIMEOUT_US = uer_pkg::ECHO_TIMEOUT_US_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [uer_pkg::TIME_W-1:0]     req_time_ms,
   input  logic [uer_pkg::TIME_W-1:0]     req_time_us,
   input  logic                           req_echo_level,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_fire_trigger,
   output logic                           rsp_reading_done,
   output logic [uer_pkg::RANGE_W-1:0]    rsp_range_mm,
   output logic                           rsp_range_valid,
   output logic                           rsp_obstacle,
   output logic [uer_pkg::TIME_W-1:0]     rsp_updated_at_ms,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [uer_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [uer_pkg::CFG_W-1:0]      csr_data
);
   import uer_pkg::*;

   logic        in_vld_ff;
   uer_req_type in_req_ff;
   logic        out_vld_ff;
   uer_rsp_type out_rsp_ff;
   uer_cfg_type cfg_ff;
   uer_rsp_type step_rsp;
   logic        advance;

   // pipeline flow
   assign advance   = in_vld_ff && (!out_vld_ff || rsp_ready);
   assign req_ready = !in_vld_ff || advance;
   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable       <= ENABLE_RST;
         cfg_ff.interval_ms  <= INTERVAL_RST;
         cfg_ff.threshold_mm <= THRESHOLD_RST;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_ENABLE:    cfg_ff.enable       <= csr_data[0];
            CSR_INTERVAL:  cfg_ff.interval_ms  <= csr_data;
            CSR_THRESHOLD: cfg_ff.threshold_mm <= csr_data;
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_ready) begin
         in_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_req_ff.time_ms    <= req_time_ms;
         in_req_ff.time_us    <= req_time_us;
         in_req_ff.echo_level <= req_echo_level;
      end
   end

   // sequencer step
   uer_core #(
      .ECHO_TIMEOUT_US (ECHO_TIMEOUT_US)
   ) u_core (
      .clock (clock),
      .reset (reset),
      .step  (advance),
      .req   (in_req_ff),
      .cfg   (cfg_ff),
      .rsp   (step_rsp)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         out_vld_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_rsp_ff <= step_rsp;
      end
   end

   assign rsp_valid         = out_vld_ff;
   assign rsp_fire_trigger  = out_rsp_ff.fire_trigger;
   assign rsp_reading_done  = out_rsp_ff.reading_done;
   assign rsp_range_mm      = out_rsp_ff.range_mm;
   assign rsp_range_valid   = out_rsp_ff.range_valid;
   assign rsp_obstacle      = out_rsp_ff.obstacle;
   assign rsp_updated_at_ms = out_rsp_ff.updated_at_ms;

endmodule
